### hw/rtl/mme_pkg.sv
// Shared types, constants and helper functions for the matrix multiply engine.
package mme_pkg;

    // Built size of the square matrices and width of one stored element
    localparam int MAX_DIM   = 16;
    localparam int ELEM_BITS = 16;

    // Derived widths
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int PROD_W = 2 * ELEM_BITS;
    localparam int SUM_W  = 40;

    // Field widths of the item ports
    localparam int IDX_W  = 4;
    localparam int VAL_W  = 16;
    localparam int SIZE_W = 5;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_SIZE_IN_USE = 1'b0;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    typedef enum logic [1:0] {
        ACT_WRITE_A = 2'd0,
        ACT_WRITE_B = 2'd1,
        ACT_COMPUTE = 2'd2
    } t_action;

    typedef struct packed {
        t_action                   action;
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          col_index;
        logic signed [VAL_W-1:0]   entry_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0]   product_value;
        logic [IDX_W-1:0]          out_row;
        logic [IDX_W-1:0]          out_col;
    } t_out_item;

    // Requests from the sequencer to the two element stores
    typedef struct packed {
        logic                      we_a;
        logic                      we_b;
        logic [ADDR_W-1:0]         waddr;
        logic [ELEM_BITS-1:0]      wdata;
        logic                      re;
        logic [ADDR_W-1:0]         raddr_a;
        logic [ADDR_W-1:0]         raddr_b;
    } t_mem_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Row-major address of element (r, c)
    function automatic logic [ADDR_W-1:0] addr_of(input int r, input int c);
        return ADDR_W'(r * MAX_DIM + c);
    endfunction

    // Keep the low ELEM_BITS bits of a written value, as a signed element
    function automatic logic signed [ELEM_BITS-1:0] to_elem(
        input logic signed [VAL_W-1:0] v
    );
        return ELEM_BITS'(v);
    endfunction

    // Active size limited to the built size
    function automatic logic [CNT_W-1:0] sat_size(input logic [SIZE_W-1:0] s);
        if (int'(s) > MAX_DIM) begin
            return CNT_W'(MAX_DIM);
        end
        return CNT_W'(s);
    endfunction

endpackage

### hw/rtl/mme_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mme_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered, loaded only while i_re is set
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/mme_ctrl.sv
// Sequencer: element writes, dot-product walk over the stores, MAC and result register.
module mme_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  mme_pkg::t_in_item             i_in_item,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output mme_pkg::t_out_item            o_out_item,
    input  logic                          i_out_stall,
    input  logic [mme_pkg::SIZE_W-1:0]    i_size,
    output mme_pkg::t_mem_req             o_mem,
    input  logic [mme_pkg::ELEM_BITS-1:0] i_rdata_a,
    input  logic [mme_pkg::ELEM_BITS-1:0] i_rdata_b
);
    import mme_pkg::*;

    t_state                   r_state, n_state;
    logic [IDX_W-1:0]         r_row;
    logic [IDX_W-1:0]         r_col;
    logic [CNT_W-1:0]         r_n;
    logic [CNT_W-1:0]         r_k;
    logic                     r_rd_v;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_v;
    logic [SUM_W-1:0]         r_sum;
    logic                     r_out_valid;
    t_out_item                r_out_item;

    logic in_acc;
    logic in_range;
    logic out_free;
    logic load_out;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign in_range = (int'(i_in_item.row_index) < MAX_DIM)
                   && (int'(i_in_item.col_index) < MAX_DIM);
    assign out_free = !r_out_valid || !i_out_stall;

    // next state and store requests
    always_comb begin
        n_state       = r_state;
        load_out      = 1'b0;
        o_mem.we_a    = 1'b0;
        o_mem.we_b    = 1'b0;
        o_mem.waddr   = addr_of(int'(i_in_item.row_index), int'(i_in_item.col_index));
        o_mem.wdata   = to_elem(i_in_item.entry_value);
        o_mem.re      = 1'b0;
        o_mem.raddr_a = addr_of(int'(r_row), int'(r_k));
        o_mem.raddr_b = addr_of(int'(r_k), int'(r_col));
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_item.action)
                        ACT_WRITE_A: o_mem.we_a = in_range;
                        ACT_WRITE_B: o_mem.we_b = in_range;
                        ACT_COMPUTE: begin
                            if (in_range && (sat_size(i_size) != '0)) begin
                                n_state   = ST_RUN;
                            end else begin
                                n_state   = ST_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                o_mem.re = 1'b1;
                if (CNT_W'(r_k + 1'b1) == r_n) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_v && !r_prod_v) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture and walk counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (in_acc && (i_in_item.action == ACT_COMPUTE)) begin
            r_k <= '0;
        end else if (r_state == ST_RUN) begin
            r_k <= CNT_W'(r_k + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_item.action == ACT_COMPUTE)) begin
            r_row <= i_in_item.row_index;
            r_col <= i_in_item.col_index;
            r_n   <= sat_size(i_size);
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_rd_v   <= o_mem.re;
            r_prod_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_prod <= $signed(i_rdata_a) * $signed(i_rdata_b);
        end
    end

    // accumulate stage, wraps at the sum width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (in_acc && (i_in_item.action == ACT_COMPUTE)) begin
            r_sum <= '0;
        end else if (r_prod_v) begin
            r_sum <= r_sum + SUM_W'(r_prod);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_item.product_value <= $signed(r_sum);
            r_out_item.out_row       <= r_row;
            r_out_item.out_col       <= r_col;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### hw/rtl/matrix_multiply_engine_top.sv
// Top level of the matrix multiply engine: configuration register and store instances.
// Holds two 16x16 matrices of signed Q8.8 elements, each written by one item (action 0 for
// the left matrix, 1 for the right). A compute item (action 2) returns one entry of the
// product, a signed Q24.16 dot product over the active size, echoed with its row and column.
// A write item never blocks the input. A compute item walks the active size, one
// multiply-accumulate per cycle, bounded by the single read port of each element store,
// through the read, multiply and accumulate stages; a zero size skips the walk, and the
// input stalls until the result is offered. Writes and new items are taken while a finished
// result still waits in the output register; a second compute result waits for it to drain.
// size_in_use sits at byte address 0 and resets to 16; only its low five bits are kept, and values 17 to 31 act as 16.
module matrix_multiply_engine_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  mme_pkg::t_in_item            i_in_item,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output mme_pkg::t_out_item           o_out_item,
    input  logic                         i_out_stall,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mme_pkg::PADDR_W-1:0]  paddr,
    input  logic [mme_pkg::PDATA_W-1:0]  pwdata,
    output logic [mme_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import mme_pkg::*;

    logic [SIZE_W-1:0]    r_size;
    t_mem_req             mem_req;
    logic [ELEM_BITS-1:0] rdata_a;
    logic [ELEM_BITS-1:0] rdata_b;
    logic                 reg_sel;

    assign reg_sel = (paddr[2] == REG_SIZE_IN_USE);

    // active size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_size <= pwdata[SIZE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_sel ? PDATA_W'(r_size) : '0;

    mme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .i_size      (r_size),
        .o_mem       (mem_req),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b)
    );

    // left matrix store
    mme_ram #(
        .DEPTH (MAX_DIM * MAX_DIM),
        .WIDTH (ELEM_BITS)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (mem_req.we_a),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr_a),
        .o_rdata (rdata_a)
    );

    // right matrix store
    mme_ram #(
        .DEPTH (MAX_DIM * MAX_DIM),
        .WIDTH (ELEM_BITS)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (mem_req.we_b),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr_b),
        .o_rdata (rdata_b)
    );

endmodule

### hw/rtl/mme_checker.sv
// Port-level checks for the matrix multiply engine, bound to the top level.
module mme_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input mme_pkg::t_in_item  i_in_item,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input mme_pkg::t_out_item o_out_item,
    input logic               i_out_stall
);
    import mme_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // a compute item keeps the block busy for at least the next cycle
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.action == ACT_COMPUTE) |=> o_in_stall)
        else $error("no busy period after compute item");

    // a write item never blocks the input
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.action != ACT_COMPUTE) |=> !o_in_stall)
        else $error("input blocked after write item");

    // a new result only follows a busy cycle
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a compute");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind matrix_multiply_engine_top mme_checker u_mme_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_item   (i_in_item),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);
